/* src/mko_pkg.sv */
package mko_pkg;

  // Sine and cosine table over one full turn. The depth is a power of two.
  localparam int TRIG_DEPTH = 1024;
  localparam int TRIG_IDX_W = $clog2(TRIG_DEPTH);
  localparam int TRIG_W     = 18;

  // Field widths.
  localparam int HEAD_W    = 16;
  localparam int ENC_W     = 32;
  localparam int DELTA_W   = ENC_W + 1;
  localparam int CMD_W     = 32;
  localparam int K16_W     = 16;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Serial multiplier: parallel operand AW bits, serial operand BW bits in DW-bit digits.
  localparam int AW    = 44;
  localparam int BW    = 32;
  localparam int DW    = 8;
  localparam int ND    = BW / DW;
  localparam int CNT_W = $clog2(ND);
  localparam int HW    = AW + DW + 2;
  localparam int PW    = 76;

  // Bit-serial divide by one hundred.
  localparam int DQW      = 44;
  localparam int DCNT_W   = $clog2(DQW);
  localparam int REM_W    = 8;
  localparam int DIVISOR  = 100;
  localparam int DIV_HALF = DIVISOR / 2;

  // Heading to table index: 1/(2*pi) in Q0.32, then the index bits of the rounded product.
  localparam logic [BW-1:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam int K_RND_SH = 44 - TRIG_IDX_W;
  localparam int K_HI     = 44;
  localparam int K_LO     = 45 - TRIG_IDX_W;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;

  // Taylor term divisors (2n)*(2n+1) in Q30, for n = 1 to 7.
  localparam longint TAYLOR_D1 = 64'sd6 <<< 30;
  localparam longint TAYLOR_D2 = 64'sd20 <<< 30;
  localparam longint TAYLOR_D3 = 64'sd42 <<< 30;
  localparam longint TAYLOR_D4 = 64'sd72 <<< 30;
  localparam longint TAYLOR_D5 = 64'sd110 <<< 30;
  localparam longint TAYLOR_D6 = 64'sd156 <<< 30;
  localparam longint TAYLOR_D7 = 64'sd210 <<< 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VX, CFG_VY, CFG_OMEGA, CFG_RADIUS, CFG_INV_RADIUS, CFG_LEVER, CFG_INV_LEVER
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_POST, ST_ROM, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_K, OP_LX1, OP_LX2, OP_LY1, OP_LY2, OP_T,
    OP_W1, OP_W2, OP_W3, OP_W4,
    OP_BX, OP_BY, OP_BT, OP_BT2,
    OP_GX1, OP_GX2, OP_GY1, OP_GY2
  } op_t;

  typedef logic signed [TRIG_W-1:0] trig_tbl_t [TRIG_DEPTH];

  // Taylor series sine of a Q30 angle in [0, 2.5*pi], result in Q16.16.
  function automatic longint sin_q30(input longint phi_in);
    longint phi;
    longint ax;
    longint x2;
    longint term;
    longint sum;
    phi = phi_in;
    if (phi > PI_Q30) phi = phi - TWO_PI_Q30;
    if (phi > HALF_PI_Q30) phi = PI_Q30 - phi;
    else if (phi < -HALF_PI_Q30) phi = -PI_Q30 - phi;
    ax = (phi < 0) ? -phi : phi;
    x2 = (ax * ax) >>> 30;
    term = phi;
    sum = phi;
    term = -((term * x2) / TAYLOR_D1);
    sum = sum + term;
    term = -((term * x2) / TAYLOR_D2);
    sum = sum + term;
    term = -((term * x2) / TAYLOR_D3);
    sum = sum + term;
    term = -((term * x2) / TAYLOR_D4);
    sum = sum + term;
    term = -((term * x2) / TAYLOR_D5);
    sum = sum + term;
    term = -((term * x2) / TAYLOR_D6);
    sum = sum + term;
    term = -((term * x2) / TAYLOR_D7);
    sum = sum + term;
    if (sum >= 0) return (sum + 64'sd8192) >>> 14;
    return -((-sum + 64'sd8192) >>> 14);
  endfunction

  function automatic trig_tbl_t make_trig(input bit cos_sel);
    trig_tbl_t tbl;
    longint phi;
    for (int k = 0; k < TRIG_DEPTH; k++) begin
      phi = (TWO_PI_Q30 * longint'(k)) / TRIG_DEPTH + (cos_sel ? HALF_PI_Q30 : 64'sd0);
      tbl[k] = TRIG_W'(sin_q30(phi));
    end
    return tbl;
  endfunction

  localparam trig_tbl_t SIN_TBL = make_trig(1'b0);
  localparam trig_tbl_t COS_TBL = make_trig(1'b1);

  // Divide by 2^sh, rounding half away from zero.
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                               input int unsigned sh);
    logic signed [PW-1:0] h;
    logic signed [PW-1:0] t;
    h = {{(PW-1){1'b0}}, 1'b1} << (sh - 1);
    t = v + h - {{(PW-1){1'b0}}, v[PW-1]};
    return t >>> sh;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [PW-1:0] v);
    if ((&v[PW-1:OUT_W-1]) || !(|v[PW-1:OUT_W-1])) return v[OUT_W-1:0];
    if (v[PW-1]) return {1'b1, {(OUT_W-1){1'b0}}};
    return {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

endpackage

/* src/mko_in_if.sv */
interface mko_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mko_pkg::HEAD_W-1:0]   heading;
  logic signed [mko_pkg::ENC_W-1:0]    enc1_angle;
  logic signed [mko_pkg::ENC_W-1:0]    enc2_angle;
  logic signed [mko_pkg::ENC_W-1:0]    enc3_angle;
  logic signed [mko_pkg::ENC_W-1:0]    enc4_angle;

  modport source(output valid, heading, enc1_angle, enc2_angle, enc3_angle, enc4_angle,
                 input ready);
  modport sink(input valid, heading, enc1_angle, enc2_angle, enc3_angle, enc4_angle,
               output ready);
endinterface

/* src/mko_out_if.sv */
interface mko_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mko_pkg::OUT_W-1:0]   wheel1_speed;
  logic signed [mko_pkg::OUT_W-1:0]   wheel2_speed;
  logic signed [mko_pkg::OUT_W-1:0]   wheel3_speed;
  logic signed [mko_pkg::OUT_W-1:0]   wheel4_speed;
  logic signed [mko_pkg::OUT_W-1:0]   pose_x;
  logic signed [mko_pkg::OUT_W-1:0]   pose_y;
  logic signed [mko_pkg::OUT_W-1:0]   pose_theta;

  modport source(output valid, wheel1_speed, wheel2_speed, wheel3_speed, wheel4_speed,
                 pose_x, pose_y, pose_theta, input ready);
  modport sink(input valid, wheel1_speed, wheel2_speed, wheel3_speed, wheel4_speed,
               pose_x, pose_y, pose_theta, output ready);
endinterface

/* src/mko_smul.sv */
// Digit-serial signed multiplier: one digit of b per cycle, least significant first.
module mko_smul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [mko_pkg::AW-1:0]    a,
  input  logic        [mko_pkg::BW-1:0]    b,
  output logic                             done,
  output logic signed [mko_pkg::PW-1:0]    prod
);

  localparam logic [mko_pkg::CNT_W-1:0] CNT_LAST = mko_pkg::CNT_W'(mko_pkg::ND - 1);

  logic                              busy_r;
  logic [mko_pkg::CNT_W-1:0]         cnt_r;
  logic signed [mko_pkg::AW-1:0]     a_r;
  logic [mko_pkg::BW-1:0]            b_r;
  logic signed [mko_pkg::HW-1:0]     hi_r;
  logic [mko_pkg::BW-1:0]            lo_r;

  logic signed [mko_pkg::DW:0]       dig;
  logic signed [mko_pkg::AW+mko_pkg::DW:0] pp;
  logic signed [mko_pkg::HW-1:0]     t;
  logic [mko_pkg::HW+mko_pkg::BW-1:0] full;

  always_comb begin
    // The top digit carries the sign of b.
    if (cnt_r == CNT_LAST) dig = {b_r[mko_pkg::DW-1], b_r[mko_pkg::DW-1:0]};
    else dig = {1'b0, b_r[mko_pkg::DW-1:0]};
    pp = a_r * dig;
    t = hi_r + {{(mko_pkg::HW-mko_pkg::AW-mko_pkg::DW-1){pp[mko_pkg::AW+mko_pkg::DW]}}, pp};
    full = {hi_r, lo_r};
    prod = full[mko_pkg::PW-1:0];
    done = busy_r && (cnt_r == CNT_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      hi_r <= '0;
      lo_r <= '0;
    end else if (busy_r) begin
      hi_r <= t >>> mko_pkg::DW;
      lo_r <= {t[mko_pkg::DW-1:0], lo_r[mko_pkg::BW-1:mko_pkg::DW]};
      b_r  <= b_r >> mko_pkg::DW;
    end
  end

endmodule

/* src/mecanum_kinematics_odometry.sv */
// Mecanum drive kinematics and odometry, one control tick per request.
// The input channel carries the heading (Q3.13) and the four absolute wheel
// encoder angles. Each result request carries the four commanded wheel speeds
// and the pose after this tick's update. The velocity command and the wheel
// geometry sit in seven registers on the write port (cfg_we, cfg_index,
// cfg_wdata); the user must make writes only while the block is idle, which
// the block itself does not enforce. Writes to unknown indexes are dropped.
// All products go through one digit-serial multiplier that takes one 8-bit
// digit per cycle; each of the eighteen products passes through operand load,
// the multiply and post-processing. The two divisions by one hundred run one
// quotient bit per cycle over a 44-bit magnitude. A new input is taken only
// once the last result is in the output register, and is taken while that
// result waits; a stalled receiver only holds the block once the next result
// is done. Reset restores the register defaults, clears the stored encoder
// readings and the pose, and empties the output register.
module mecanum_kinematics_odometry (
  input  logic                              clk,
  input  logic                              rst_n,
  mko_in_if.sink                            in_ch,
  mko_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [mko_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mko_pkg::CMD_W-1:0]         cfg_wdata
);

  localparam int AW  = mko_pkg::AW;
  localparam int PW  = mko_pkg::PW;
  localparam int DQW = mko_pkg::DQW;

  // Configuration registers.
  logic signed [mko_pkg::CMD_W-1:0] cmd_vx_r, cmd_vy_r, cmd_omega_r;
  logic [mko_pkg::K16_W-1:0]        wheel_radius_r, inv_wheel_radius_r;
  logic [mko_pkg::K16_W-1:0]        lever_sum_r, inv_lever_sum_r;

  // Control.
  mko_pkg::state_t state_r, state_nxt;
  mko_pkg::op_t    op_r, op_nxt;
  logic            in_fire, out_load, mul_start, mul_done, div_last;

  // Item state.
  logic signed [mko_pkg::ENC_W-1:0]   prev_enc_r [4];
  logic signed [mko_pkg::ENC_W-1:0]   enc_in [4];
  logic signed [mko_pkg::DELTA_W-1:0] d_r [4];
  logic signed [mko_pkg::HEAD_W-1:0]  heading_r;
  logic [mko_pkg::TRIG_IDX_W-1:0]     idx_r;
  logic signed [mko_pkg::TRIG_W-1:0]  c_r, s_r;
  logic signed [PW-1:0]               acc_r;
  logic signed [AW-1:0]               lx_r, ly_r, turn_r, bx_r, by_r, btp_r;
  logic signed [mko_pkg::OUT_W-1:0]   w_r [4];
  logic signed [mko_pkg::OUT_W-1:0]   pose_x_r, pose_y_r, pose_t_r;

  // Divider.
  logic [DQW-1:0]                 dq_r;
  logic [mko_pkg::REM_W-1:0]      rem_r;
  logic [mko_pkg::DCNT_W-1:0]     div_cnt_r;
  logic                           neg_r;

  // Output register.
  logic                              out_valid_r;
  logic signed [mko_pkg::OUT_W-1:0]  out_w_r [4];
  logic signed [mko_pkg::OUT_W-1:0]  out_px_r, out_py_r, out_pt_r;

  // Datapath signals.
  logic signed [AW-1:0]           mul_a;
  logic [mko_pkg::BW-1:0]         mul_b;
  logic signed [PW-1:0]           mul_p;
  logic signed [PW-1:0]           sum_add, sum_sub, k_sum;
  logic signed [PW-1:0]           r16_add, r16_sub, r16_p, r10_p, r8_p, r18_p;
  logic signed [PW-1:0]           g_val, g_mag, q_ext, quot_s, pose_sum;
  logic signed [PW-1:0]           theta_sum;
  logic                           g_neg;
  logic [DQW-1:0]                 div_load, quot;
  logic [mko_pkg::REM_W-1:0]      rem_sh, rem_step;
  logic                           q_bit;

  assign enc_in[0] = in_ch.enc1_angle;
  assign enc_in[1] = in_ch.enc2_angle;
  assign enc_in[2] = in_ch.enc3_angle;
  assign enc_in[3] = in_ch.enc4_angle;

  assign in_ch.ready = (state_r == mko_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == mko_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);
  assign div_last    = (div_cnt_r == mko_pkg::DCNT_W'(DQW - 1));

  assign out_ch.valid        = out_valid_r;
  assign out_ch.wheel1_speed = out_w_r[0];
  assign out_ch.wheel2_speed = out_w_r[1];
  assign out_ch.wheel3_speed = out_w_r[2];
  assign out_ch.wheel4_speed = out_w_r[3];
  assign out_ch.pose_x       = out_px_r;
  assign out_ch.pose_y       = out_py_r;
  assign out_ch.pose_theta   = out_pt_r;

  mko_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // Operand selection for the shared multiplier, one product per operation.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      mko_pkg::OP_K: begin
        mul_a = AW'(heading_r);
        mul_b = mko_pkg::INV_TWO_PI_Q32;
      end
      mko_pkg::OP_LX1: begin mul_a = AW'(cmd_vx_r); mul_b = mko_pkg::BW'(c_r); end
      mko_pkg::OP_LX2: begin mul_a = AW'(cmd_vy_r); mul_b = mko_pkg::BW'(s_r); end
      mko_pkg::OP_LY1: begin mul_a = AW'(cmd_vy_r); mul_b = mko_pkg::BW'(c_r); end
      mko_pkg::OP_LY2: begin mul_a = AW'(cmd_vx_r); mul_b = mko_pkg::BW'(s_r); end
      mko_pkg::OP_T: begin
        mul_a = AW'(cmd_omega_r);
        mul_b = mko_pkg::BW'(lever_sum_r);
      end
      mko_pkg::OP_W1: begin
        mul_a = lx_r + ly_r + turn_r;
        mul_b = mko_pkg::BW'(inv_wheel_radius_r);
      end
      mko_pkg::OP_W2: begin
        mul_a = lx_r - ly_r - turn_r;
        mul_b = mko_pkg::BW'(inv_wheel_radius_r);
      end
      mko_pkg::OP_W3: begin
        mul_a = lx_r - ly_r + turn_r;
        mul_b = mko_pkg::BW'(inv_wheel_radius_r);
      end
      mko_pkg::OP_W4: begin
        mul_a = lx_r + ly_r - turn_r;
        mul_b = mko_pkg::BW'(inv_wheel_radius_r);
      end
      mko_pkg::OP_BX: begin
        mul_a = AW'(d_r[0]) + AW'(d_r[1]) + AW'(d_r[2]) + AW'(d_r[3]);
        mul_b = mko_pkg::BW'(wheel_radius_r);
      end
      mko_pkg::OP_BY: begin
        mul_a = AW'(d_r[0]) - AW'(d_r[1]) - AW'(d_r[2]) + AW'(d_r[3]);
        mul_b = mko_pkg::BW'(wheel_radius_r);
      end
      mko_pkg::OP_BT: begin
        mul_a = AW'(d_r[0]) - AW'(d_r[1]) + AW'(d_r[2]) - AW'(d_r[3]);
        mul_b = mko_pkg::BW'(wheel_radius_r);
      end
      mko_pkg::OP_BT2: begin mul_a = btp_r; mul_b = mko_pkg::BW'(inv_lever_sum_r); end
      mko_pkg::OP_GX1: begin mul_a = bx_r; mul_b = mko_pkg::BW'(c_r); end
      mko_pkg::OP_GX2: begin mul_a = by_r; mul_b = mko_pkg::BW'(s_r); end
      mko_pkg::OP_GY1: begin mul_a = bx_r; mul_b = mko_pkg::BW'(s_r); end
      mko_pkg::OP_GY2: begin mul_a = by_r; mul_b = mko_pkg::BW'(c_r); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounding of the finished product, the divider step and the pose sums.
  always_comb begin
    sum_add = acc_r + mul_p;
    sum_sub = acc_r - mul_p;
    k_sum   = mul_p + ({{(PW-1){1'b0}}, 1'b1} << mko_pkg::K_RND_SH);
    r16_add = mko_pkg::rnd(sum_add, 16);
    r16_sub = mko_pkg::rnd(sum_sub, 16);
    r16_p   = mko_pkg::rnd(mul_p, 16);
    r10_p   = mko_pkg::rnd(mul_p, 10);
    r8_p    = mko_pkg::rnd(mul_p, 8);
    r18_p   = mko_pkg::rnd(mul_p, 18);

    // x takes c*bx - s*by and y takes s*bx + c*by, both from the original bx.
    g_val    = (op_r == mko_pkg::OP_GX2) ? r16_sub : r16_add;
    g_neg    = g_val[PW-1];
    g_mag    = g_neg ? -g_val : g_val;
    div_load = g_mag[DQW-1:0] + DQW'(mko_pkg::DIV_HALF);

    // Restoring division of the magnitude by one hundred, one quotient bit per cycle.
    rem_sh   = {rem_r[mko_pkg::REM_W-2:0], dq_r[DQW-1]};
    q_bit    = (rem_sh >= mko_pkg::REM_W'(mko_pkg::DIVISOR));
    rem_step = q_bit ? rem_sh - mko_pkg::REM_W'(mko_pkg::DIVISOR) : rem_sh;
    quot     = {dq_r[DQW-2:0], q_bit};
    q_ext    = {{(PW-DQW){1'b0}}, quot};
    quot_s   = neg_r ? -q_ext : q_ext;
    pose_sum = ((op_r == mko_pkg::OP_GX2) ? PW'(pose_x_r) : PW'(pose_y_r)) + quot_s;
    theta_sum = PW'(pose_t_r) + r18_p;
  end

  // Sequencer: next state and next operation.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    mul_start = 1'b0;
    case (state_r)
      mko_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = mko_pkg::ST_LOAD;
          op_nxt    = mko_pkg::OP_K;
        end
      end
      mko_pkg::ST_LOAD: begin
        mul_start = 1'b1;
        state_nxt = mko_pkg::ST_MUL;
      end
      mko_pkg::ST_MUL: begin
        if (mul_done) state_nxt = mko_pkg::ST_POST;
      end
      mko_pkg::ST_POST: begin
        state_nxt = mko_pkg::ST_LOAD;
        case (op_r)
          mko_pkg::OP_K:   state_nxt = mko_pkg::ST_ROM;
          mko_pkg::OP_LX1: op_nxt = mko_pkg::OP_LX2;
          mko_pkg::OP_LX2: op_nxt = mko_pkg::OP_LY1;
          mko_pkg::OP_LY1: op_nxt = mko_pkg::OP_LY2;
          mko_pkg::OP_LY2: op_nxt = mko_pkg::OP_T;
          mko_pkg::OP_T:   op_nxt = mko_pkg::OP_W1;
          mko_pkg::OP_W1:  op_nxt = mko_pkg::OP_W2;
          mko_pkg::OP_W2:  op_nxt = mko_pkg::OP_W3;
          mko_pkg::OP_W3:  op_nxt = mko_pkg::OP_W4;
          mko_pkg::OP_W4:  op_nxt = mko_pkg::OP_BX;
          mko_pkg::OP_BX:  op_nxt = mko_pkg::OP_BY;
          mko_pkg::OP_BY:  op_nxt = mko_pkg::OP_BT;
          mko_pkg::OP_BT:  op_nxt = mko_pkg::OP_BT2;
          mko_pkg::OP_BT2: op_nxt = mko_pkg::OP_GX1;
          mko_pkg::OP_GX1: op_nxt = mko_pkg::OP_GX2;
          mko_pkg::OP_GX2: state_nxt = mko_pkg::ST_DIV;
          mko_pkg::OP_GY1: op_nxt = mko_pkg::OP_GY2;
          mko_pkg::OP_GY2: state_nxt = mko_pkg::ST_DIV;
          default:         state_nxt = mko_pkg::ST_IDLE;
        endcase
      end
      mko_pkg::ST_ROM: begin
        state_nxt = mko_pkg::ST_LOAD;
        op_nxt    = mko_pkg::OP_LX1;
      end
      mko_pkg::ST_DIV: begin
        if (div_last) begin
          if (op_r == mko_pkg::OP_GX2) begin
            state_nxt = mko_pkg::ST_LOAD;
            op_nxt    = mko_pkg::OP_GY1;
          end else begin
            state_nxt = mko_pkg::ST_DONE;
          end
        end
      end
      mko_pkg::ST_DONE: begin
        if (out_load) state_nxt = mko_pkg::ST_IDLE;
      end
      default: state_nxt = mko_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mko_pkg::ST_IDLE;
      op_r    <= mko_pkg::OP_K;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vx_r           <= '0;
      cmd_vy_r           <= '0;
      cmd_omega_r        <= 32'sd65536;
      wheel_radius_r     <= 16'd1280;
      inv_wheel_radius_r <= 16'd13107;
      lever_sum_r        <= 16'd9882;
      inv_lever_sum_r    <= 16'd1698;
    end else if (cfg_we) begin
      case (cfg_index)
        mko_pkg::CFG_VX:         cmd_vx_r           <= cfg_wdata;
        mko_pkg::CFG_VY:         cmd_vy_r           <= cfg_wdata;
        mko_pkg::CFG_OMEGA:      cmd_omega_r        <= cfg_wdata;
        mko_pkg::CFG_RADIUS:     wheel_radius_r     <= cfg_wdata[mko_pkg::K16_W-1:0];
        mko_pkg::CFG_INV_RADIUS: inv_wheel_radius_r <= cfg_wdata[mko_pkg::K16_W-1:0];
        mko_pkg::CFG_LEVER:      lever_sum_r        <= cfg_wdata[mko_pkg::K16_W-1:0];
        mko_pkg::CFG_INV_LEVER:  inv_lever_sum_r    <= cfg_wdata[mko_pkg::K16_W-1:0];
        default: ;
      endcase
    end
  end

  // Stored encoder readings, pose accumulators and the output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) prev_enc_r[i] <= '0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_t_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        for (int i = 0; i < 4; i++) prev_enc_r[i] <= enc_in[i];
      end
      if (state_r == mko_pkg::ST_POST && op_r == mko_pkg::OP_BT2) begin
        pose_t_r <= mko_pkg::sat32(theta_sum);
      end
      if (state_r == mko_pkg::ST_DIV && div_last) begin
        if (op_r == mko_pkg::OP_GX2) pose_x_r <= mko_pkg::sat32(pose_sum);
        else pose_y_r <= mko_pkg::sat32(pose_sum);
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      heading_r <= in_ch.heading;
      for (int i = 0; i < 4; i++) begin
        d_r[i] <= mko_pkg::DELTA_W'(enc_in[i]) - mko_pkg::DELTA_W'(prev_enc_r[i]);
      end
    end
    if (state_r == mko_pkg::ST_ROM) begin
      c_r <= mko_pkg::COS_TBL[idx_r];
      s_r <= mko_pkg::SIN_TBL[idx_r];
    end
    if (state_r == mko_pkg::ST_POST) begin
      case (op_r)
        mko_pkg::OP_K:   idx_r <= k_sum[mko_pkg::K_HI:mko_pkg::K_LO];
        mko_pkg::OP_LX1: acc_r <= mul_p;
        mko_pkg::OP_LX2: lx_r <= r16_add[AW-1:0];
        mko_pkg::OP_LY1: acc_r <= mul_p;
        mko_pkg::OP_LY2: ly_r <= r16_sub[AW-1:0];
        mko_pkg::OP_T:   turn_r <= r8_p[AW-1:0];
        mko_pkg::OP_W1:  w_r[0] <= mko_pkg::sat32(r16_p);
        mko_pkg::OP_W2:  w_r[1] <= mko_pkg::sat32(r16_p);
        mko_pkg::OP_W3:  w_r[2] <= mko_pkg::sat32(r16_p);
        mko_pkg::OP_W4:  w_r[3] <= mko_pkg::sat32(r16_p);
        mko_pkg::OP_BX:  bx_r <= r10_p[AW-1:0];
        mko_pkg::OP_BY:  by_r <= r10_p[AW-1:0];
        mko_pkg::OP_BT:  btp_r <= r8_p[AW-1:0];
        mko_pkg::OP_GX1: acc_r <= mul_p;
        mko_pkg::OP_GY1: acc_r <= mul_p;
        mko_pkg::OP_GX2, mko_pkg::OP_GY2: begin
          dq_r      <= div_load;
          rem_r     <= '0;
          neg_r     <= g_neg;
          div_cnt_r <= '0;
        end
        default: ;
      endcase
    end
    if (state_r == mko_pkg::ST_DIV) begin
      dq_r      <= quot;
      rem_r     <= rem_step;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (out_load) begin
      for (int i = 0; i < 4; i++) out_w_r[i] <= w_r[i];
      out_px_r <= pose_x_r;
      out_py_r <= pose_y_r;
      out_pt_r <= pose_t_r;
    end
  end

endmodule

/* dv/mko_checker.sv */
`timescale 1ns / 1ps

module mko_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  mko_in_if                                 in_ch,
  mko_out_if                                out_ch,
  input  logic                              cfg_we,
  input  logic [mko_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mko_pkg::CMD_W-1:0]         cfg_wdata,
  output int                                errors,
  output int                                pending
);

  localparam int N = mko_pkg::TRIG_DEPTH;

  typedef struct packed {
    logic signed [31:0] w1, w2, w3, w4, px, py, pt;
  } tick_result_t;

  tick_result_t expected_ticks [$];
  longint sine_q16 [N];
  longint cosine_q16 [N];

  // Shadow copy of the registers and of the odometry state.
  longint vx, vy, omega, radius, inv_radius, lever, inv_lever;
  longint last_enc [4];
  longint pose_x, pose_y, pose_th;

  function automatic longint round_shift(input longint v, input int s);
    longint h;
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint centi(input longint v);
    if (v >= 0) return (v + 50) / 100;
    return -((-v + 50) / 100);
  endfunction

  // Eight-term Taylor sine of a Q30 angle, folded to [-pi/2, pi/2].
  function automatic longint taylor_sine(input longint a);
    longint sq, term, acc, mag;
    a = (a > 64'sd3373259426) ? a - 64'sd6746518852 : a;
    if (a > 64'sd1686629713) a = 64'sd3373259426 - a;
    else if (a < -64'sd1686629713) a = -64'sd3373259426 - a;
    mag = (a < 0) ? -a : a;
    sq = (mag * mag) >>> 30;
    term = a;
    acc = a;
    for (int n = 1; n <= 7; n++) begin
      term = -((term * sq) / (longint'(2 * n) * longint'(2 * n + 1) * (64'sd1 <<< 30)));
      acc = acc + term;
    end
    return round_shift(acc, 14);
  endfunction

  function automatic tick_result_t predict_tick(input longint hd, input longint enc [4]);
    tick_result_t r;
    longint t, k, c, s, lx, ly, turn, w [4], d [4], bx, by, bt, gx, gy;
    t = hd * N * 64'sd683565276 + (64'sd1 <<< 44);
    k = t >>> 45;
    k = k % N;
    if (k < 0) k = k + N;
    c = cosine_q16[k];
    s = sine_q16[k];
    lx = round_shift(c * vx + s * vy, 16);
    ly = round_shift(c * vy - s * vx, 16);
    turn = round_shift(lever * omega, 8);
    w[0] = lx + ly + turn;
    w[1] = lx - ly - turn;
    w[2] = lx - ly + turn;
    w[3] = lx + ly - turn;
    for (int i = 0; i < 4; i++) begin
      w[i] = clamp32(round_shift(w[i] * inv_radius, 16));
      d[i] = enc[i] - last_enc[i];
      last_enc[i] = enc[i];
    end
    bx = round_shift(radius * (d[0] + d[1] + d[2] + d[3]), 10);
    by = round_shift(radius * (d[0] - d[1] - d[2] + d[3]), 10);
    bt = round_shift(round_shift(radius * (d[0] - d[1] + d[2] - d[3]), 8) * inv_lever, 18);
    // The world rotation uses the body x from before the update for both axes.
    gx = round_shift(c * bx - s * by, 16);
    gy = round_shift(s * bx + c * by, 16);
    pose_x = clamp32(pose_x + centi(gx));
    pose_y = clamp32(pose_y + centi(gy));
    pose_th = clamp32(pose_th + bt);
    r.w1 = w[0]; r.w2 = w[1]; r.w3 = w[2]; r.w4 = w[3];
    r.px = pose_x; r.py = pose_y; r.pt = pose_th;
    return r;
  endfunction

  initial begin
    for (int k = 0; k < N; k++) begin
      sine_q16[k] = taylor_sine((64'sd6746518852 * k) / N);
      cosine_q16[k] = taylor_sine((64'sd6746518852 * k) / N + 64'sd1686629713);
    end
  end

  task automatic report(input string field, input longint exp_v, input longint act_v);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    longint enc [4];
    tick_result_t exp_r;
    if (!rst_n) begin
      vx = 0; vy = 0; omega = 65536;
      radius = 1280; inv_radius = 13107; lever = 9882; inv_lever = 1698;
      for (int i = 0; i < 4; i++) last_enc[i] = 0;
      pose_x = 0; pose_y = 0; pose_th = 0;
      expected_ticks.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mko_pkg::CFG_VX:         vx = longint'($signed(cfg_wdata));
          mko_pkg::CFG_VY:         vy = longint'($signed(cfg_wdata));
          mko_pkg::CFG_OMEGA:      omega = longint'($signed(cfg_wdata));
          mko_pkg::CFG_RADIUS:     radius = cfg_wdata[15:0];
          mko_pkg::CFG_INV_RADIUS: inv_radius = cfg_wdata[15:0];
          mko_pkg::CFG_LEVER:      lever = cfg_wdata[15:0];
          mko_pkg::CFG_INV_LEVER:  inv_lever = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_ticks.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result request with nothing expected", $realtime);
        end else begin
          exp_r = expected_ticks.pop_front();
          if (out_ch.wheel1_speed !== exp_r.w1)
            report("wheel1_speed", exp_r.w1, out_ch.wheel1_speed);
          if (out_ch.wheel2_speed !== exp_r.w2)
            report("wheel2_speed", exp_r.w2, out_ch.wheel2_speed);
          if (out_ch.wheel3_speed !== exp_r.w3)
            report("wheel3_speed", exp_r.w3, out_ch.wheel3_speed);
          if (out_ch.wheel4_speed !== exp_r.w4)
            report("wheel4_speed", exp_r.w4, out_ch.wheel4_speed);
          if (out_ch.pose_x !== exp_r.px) report("pose_x", exp_r.px, out_ch.pose_x);
          if (out_ch.pose_y !== exp_r.py) report("pose_y", exp_r.py, out_ch.pose_y);
          if (out_ch.pose_theta !== exp_r.pt)
            report("pose_theta", exp_r.pt, out_ch.pose_theta);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        enc[0] = in_ch.enc1_angle;
        enc[1] = in_ch.enc2_angle;
        enc[2] = in_ch.enc3_angle;
        enc[3] = in_ch.enc4_angle;
        expected_ticks.push_back(predict_tick(longint'(in_ch.heading), enc));
      end
    end
    pending = expected_ticks.size();
  end

endmodule

/* dv/mecanum_kinematics_odometry_test.sv */
`timescale 1ns / 1ps

module mecanum_kinematics_odometry_test;

  // Index 7 decodes to no register; writes there must be dropped.
  localparam logic [mko_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  // A quiet spell many times longer than one tick takes is treated as a hang.
  localparam int HANG_LIMIT = 8000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mko_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mko_pkg::CMD_W-1:0] cfg_wdata;
  int errors;
  int pending;
  int ticks_sent;
  int results_seen;
  int quiet_cycles;
  bit calm;
  logic signed [31:0] enc [4];

  mko_in_if  in_ch ();
  mko_out_if out_ch ();

  mecanum_kinematics_odometry dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mko_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls about a third of the time, except during the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 34);
  end

  // Hang detection: any cycle that moves a request on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
      results_seen <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
      if (out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [mko_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait until every predicted tick has come back, so the block is idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one tick; outside the calm stretch the sender may sit idle first.
  task automatic send_tick(input logic signed [15:0] hd);
    while (!calm && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.heading <= hd;
    in_ch.enc1_angle <= enc[0];
    in_ch.enc2_angle <= enc[1];
    in_ch.enc3_angle <= enc[2];
    in_ch.enc4_angle <= enc[3];
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
  endtask

  task automatic random_geometry(input bit wild);
    write_reg(mko_pkg::CFG_VX, wild ? $urandom : $urandom_range(400000) - 200000);
    write_reg(mko_pkg::CFG_VY, wild ? $urandom : $urandom_range(400000) - 200000);
    write_reg(mko_pkg::CFG_OMEGA, wild ? $urandom : $urandom_range(200000) - 100000);
    write_reg(mko_pkg::CFG_RADIUS, wild ? $urandom_range(65535, 1) : $urandom_range(3000, 200));
    write_reg(mko_pkg::CFG_INV_RADIUS, $urandom_range(65535, 1));
    write_reg(mko_pkg::CFG_LEVER, wild ? $urandom_range(65535, 1) : $urandom_range(20000, 1000));
    write_reg(mko_pkg::CFG_INV_LEVER, $urandom_range(65535, 1));
  endtask

  // Most ticks look like a robot driving: encoders move a little each time.
  // The rest jump anywhere, and some headings lie outside the nominal range.
  task automatic random_ticks(input int count);
    logic signed [15:0] hd;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 80) begin
        for (int i = 0; i < 4; i++) enc[i] = enc[i] + $signed($urandom_range(8000)) - 4000;
      end else begin
        for (int i = 0; i < 4; i++) enc[i] = $urandom;
      end
      hd = ($urandom_range(99) < 70) ? 16'($signed($urandom_range(51472)) - 25736)
                                     : 16'($urandom);
      send_tick(hd);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mko_pkg::CFG_VX;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.heading = '0;
    in_ch.enc1_angle = '0;
    in_ch.enc2_angle = '0;
    in_ch.enc3_angle = '0;
    in_ch.enc4_angle = '0;
    calm = 1'b0;
    ticks_sent = 0;
    for (int i = 0; i < 4; i++) enc[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks with the reset geometry: heading extremes, including values
    // beyond the nominal range that wrap the table index, and zero motion.
    send_tick(16'sd0);
    send_tick(16'sd25736);
    send_tick(-16'sd25736);
    send_tick(16'sh7FFF);
    send_tick(16'sh8000);
    drain();

    // Full-scale commands and geometry; large encoder jumps push the pose
    // accumulators into saturation in both directions.
    write_reg(mko_pkg::CFG_VX, 32'h7FFF_FFFF);
    write_reg(mko_pkg::CFG_VY, 32'h8000_0000);
    write_reg(mko_pkg::CFG_OMEGA, 32'h7FFF_FFFF);
    write_reg(mko_pkg::CFG_RADIUS, 32'd65535);
    write_reg(mko_pkg::CFG_INV_RADIUS, 32'd65535);
    write_reg(mko_pkg::CFG_LEVER, 32'd65535);
    write_reg(mko_pkg::CFG_INV_LEVER, 32'd65535);
    for (int n = 0; n < 4; n++) begin
      enc[0] = 32'sh7FFF_FFFF; enc[1] = 32'sh8000_0000;
      enc[2] = 32'sh7FFF_FFFF; enc[3] = 32'sh8000_0000;
      send_tick(16'(n * 6434));
      for (int i = 0; i < 4; i++) enc[i] = ~enc[i];
      send_tick(16'(-n * 6434));
    end
    drain();

    write_reg(mko_pkg::CFG_VX, 32'h8000_0000);
    write_reg(mko_pkg::CFG_VY, 32'h7FFF_FFFF);
    write_reg(mko_pkg::CFG_OMEGA, 32'h8000_0000);
    // An unmapped index must leave every register alone.
    write_reg(CFG_UNMAPPED, 32'h0000_0000);
    enc[0] = 32'sh8000_0000; enc[1] = 32'sh7FFF_FFFF;
    enc[2] = 32'sh8000_0000; enc[3] = 32'sh7FFF_FFFF;
    send_tick(16'sd12868);
    send_tick(-16'sd12868);
    drain();

    // Zeroed constants are used as given, so speeds and motion collapse to zero.
    write_reg(mko_pkg::CFG_RADIUS, 32'd0);
    write_reg(mko_pkg::CFG_INV_RADIUS, 32'd0);
    write_reg(mko_pkg::CFG_LEVER, 32'd0);
    write_reg(mko_pkg::CFG_INV_LEVER, 32'd0);
    enc[0] = 32'sd1000; enc[1] = -32'sd1000; enc[2] = 32'sd5; enc[3] = 32'sd77;
    send_tick(16'sd3000);
    send_tick(-16'sd3000);
    drain();

    // Random phases, each under a fresh geometry, one of them without any idling.
    for (int phase = 0; phase < 8; phase++) begin
      random_geometry(phase % 3 == 2);
      calm = (phase == 4);
      random_ticks(100);
      drain();
    end
    calm = 1'b0;
    random_geometry(1'b0);
    random_ticks(30);
    drain();

    repeat (250) @(posedge clk);
    $display("Sent %0d ticks and checked %0d results over directed extremes,", ticks_sent,
             results_seen);
    $display("saturation, zero constants, an unmapped write and nine random geometries.");
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
